// ===== rtl/eulr_pkg.sv =====
`timescale 1ns / 1ps

package eulr_pkg;

  localparam int DATA_W       = 32;
  localparam int MAT_FRAC     = 30;
  localparam int ANGLE_W      = 26;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int CORDIC_ITERS = 31;
  localparam int UOP_LAST     = 14;

  localparam logic [37:0] PHASE_PER_DEG = 38'd3054198966;
  localparam logic [37:0] PHASE_PER_RAD = 38'd174992710547;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Z = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEGREES = 3'd3;

  // operations
  localparam logic [1:0] OP_FWD    = 2'd0;
  localparam logic [1:0] OP_INV    = 2'd1;
  localparam logic [1:0] OP_TENSOR = 2'd2;

  // operand codes for the matrix build
  localparam logic [3:0] OPD_CZ  = 4'd0;
  localparam logic [3:0] OPD_SZ  = 4'd1;
  localparam logic [3:0] OPD_CX  = 4'd2;
  localparam logic [3:0] OPD_SX  = 4'd3;
  localparam logic [3:0] OPD_CY  = 4'd4;
  localparam logic [3:0] OPD_SY  = 4'd5;
  localparam logic [3:0] OPD_T1  = 4'd6;
  localparam logic [3:0] OPD_T3  = 4'd7;
  localparam logic [3:0] OPD_ONE = 4'd8;

  // destinations: matrix entries 0..8, then temporaries
  localparam logic [3:0] DST_T1 = 4'd9;
  localparam logic [3:0] DST_T3 = 4'd10;

  typedef enum logic [1:0] {ACC_SET, ACC_ADD, ACC_SUB, ACC_NEG} acc_mode_t;

  typedef struct packed {
    logic [3:0] src_a;
    logic [3:0] src_b;
    logic [3:0] dst;
    acc_mode_t  mode;
    logic       last;
  } uop_t;

  typedef enum logic [3:0] {
    MG_IDLE, MG_PH_LO, MG_PH_HI, MG_PH_SUM, MG_CINIT,
    MG_CORDIC, MG_MAP, MG_MUL, MG_ACC
  } mg_state_t;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [DATA_W-1:0] in_c0;
    logic signed [DATA_W-1:0] in_c1;
    logic signed [DATA_W-1:0] in_c2;
    logic signed [DATA_W-1:0] in_c3;
    logic signed [DATA_W-1:0] in_c4;
    logic signed [DATA_W-1:0] in_c5;
    logic signed [DATA_W-1:0] in_c6;
    logic signed [DATA_W-1:0] in_c7;
    logic signed [DATA_W-1:0] in_c8;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_c0;
    logic signed [DATA_W-1:0] out_c1;
    logic signed [DATA_W-1:0] out_c2;
    logic signed [DATA_W-1:0] out_c3;
    logic signed [DATA_W-1:0] out_c4;
    logic signed [DATA_W-1:0] out_c5;
    logic signed [DATA_W-1:0] out_c6;
    logic signed [DATA_W-1:0] out_c7;
    logic signed [DATA_W-1:0] out_c8;
  } out_item_t;

  function automatic logic [29:0] atan_at(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // matrix build program, each entry formed in consecutive steps
  function automatic uop_t uop_at(input logic [3:0] step);
    uop_t u;
    case (step)
      4'd0:  u = '{OPD_SX, OPD_SY,  DST_T1, ACC_SET, 1'b1};
      4'd1:  u = '{OPD_SX, OPD_CY,  DST_T3, ACC_SET, 1'b1};
      4'd2:  u = '{OPD_CY, OPD_CZ,  4'd0,   ACC_SET, 1'b0};
      4'd3:  u = '{OPD_T1, OPD_SZ,  4'd0,   ACC_SUB, 1'b1};
      4'd4:  u = '{OPD_CX, OPD_SZ,  4'd1,   ACC_NEG, 1'b1};
      4'd5:  u = '{OPD_T3, OPD_SZ,  4'd2,   ACC_SET, 1'b0};
      4'd6:  u = '{OPD_SY, OPD_CZ,  4'd2,   ACC_ADD, 1'b1};
      4'd7:  u = '{OPD_CY, OPD_SZ,  4'd3,   ACC_SET, 1'b0};
      4'd8:  u = '{OPD_T1, OPD_CZ,  4'd3,   ACC_ADD, 1'b1};
      4'd9:  u = '{OPD_CX, OPD_CZ,  4'd4,   ACC_SET, 1'b1};
      4'd10: u = '{OPD_SY, OPD_SZ,  4'd5,   ACC_SET, 1'b0};
      4'd11: u = '{OPD_T3, OPD_CZ,  4'd5,   ACC_SUB, 1'b1};
      4'd12: u = '{OPD_CX, OPD_SY,  4'd6,   ACC_NEG, 1'b1};
      4'd13: u = '{OPD_SX, OPD_ONE, 4'd7,   ACC_SET, 1'b1};
      4'd14: u = '{OPD_CX, OPD_CY,  4'd8,   ACC_SET, 1'b1};
      default: u = '{OPD_ONE, OPD_ONE, DST_T1, ACC_SET, 1'b1};
    endcase
    return u;
  endfunction

endpackage

// ===== rtl/eulr_matgen.sv =====
`timescale 1ns / 1ps

module eulr_matgen (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [eulr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [eulr_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                  idle,
  output logic signed [eulr_pkg::DATA_W-1:0]    rot_matrix [9]
);

  eulr_pkg::mg_state_t state_r, state_nxt;

  logic signed [eulr_pkg::ANGLE_W-1:0] ang_z_r, ang_x_r, ang_y_r;
  logic                                deg_r;
  logic [1:0]                          ang_sel_r;
  logic [4:0]                          iter_r;
  logic [3:0]                          step_r;
  logic signed [45:0]                  plo_r, phi_r;
  logic [31:0]                         phase_r;
  logic [1:0]                          quad_r;
  logic signed [33:0]                  x_r, y_r, z_r;
  logic signed [31:0]                  sc_r [6];
  logic signed [31:0]                  t1_r, t3_r;
  logic signed [63:0]                  prod_r;
  logic signed [33:0]                  acc_r;
  logic signed [31:0]                  rot_r [9];

  logic                                cfg_hit;
  logic signed [eulr_pkg::ANGLE_W-1:0] ang_cur;
  logic [37:0]                         kmul;
  logic signed [55:0]                  phase_sum;
  logic [31:0]                         qsum, dsub;
  logic signed [33:0]                  dx, dy, atan_ext;
  logic signed [33:0]                  xc, yc;
  logic signed [31:0]                  c_map, s_map;
  eulr_pkg::uop_t                      uop;
  logic signed [31:0]                  opd_a, opd_b;
  logic signed [63:0]                  prod_rnd;
  logic signed [33:0]                  rq, acc_nxt, acc_clamp;

  assign cfg_ready = (state_r == eulr_pkg::MG_IDLE);
  assign idle      = (state_r == eulr_pkg::MG_IDLE);
  assign cfg_hit   = cfg_valid && (cfg_index <= eulr_pkg::REG_DEGREES);

  always_comb begin
    for (int i = 0; i < 9; i++) rot_matrix[i] = rot_r[i];
  end

  function automatic logic signed [31:0] pick(
    input logic [3:0] code, input logic signed [31:0] sc [6],
    input logic signed [31:0] t1, input logic signed [31:0] t3);
    logic signed [31:0] v;
    case (code)
      eulr_pkg::OPD_CZ: v = sc[0];
      eulr_pkg::OPD_SZ: v = sc[1];
      eulr_pkg::OPD_CX: v = sc[2];
      eulr_pkg::OPD_SX: v = sc[3];
      eulr_pkg::OPD_CY: v = sc[4];
      eulr_pkg::OPD_SY: v = sc[5];
      eulr_pkg::OPD_T1: v = t1;
      eulr_pkg::OPD_T3: v = t3;
      default:          v = eulr_pkg::ONE_Q30[31:0];
    endcase
    return v;
  endfunction

  function automatic logic signed [33:0] clamp1(input logic signed [33:0] v);
    logic signed [33:0] r;
    if (v > eulr_pkg::ONE_Q30) r = eulr_pkg::ONE_Q30;
    else if (v < -eulr_pkg::ONE_Q30) r = -eulr_pkg::ONE_Q30;
    else r = v;
    return r;
  endfunction

  always_comb begin
    case (ang_sel_r)
      2'd0:    ang_cur = ang_z_r;
      2'd1:    ang_cur = ang_x_r;
      default: ang_cur = ang_y_r;
    endcase
    kmul = deg_r ? eulr_pkg::PHASE_PER_DEG : eulr_pkg::PHASE_PER_RAD;

    // phase = (angle * k + 2^23) >> 24, wrapped to 32 bits
    phase_sum = 56'(plo_r) + (56'(phi_r) <<< 19) + 56'sd8388608;

    qsum = phase_r + 32'h2000_0000;
    dsub = phase_r - {qsum[31:30], 30'd0};

    dx       = y_r >>> iter_r;
    dy       = x_r >>> iter_r;
    atan_ext = 34'(eulr_pkg::atan_at(iter_r));

    xc = clamp1(x_r);
    yc = clamp1(y_r);
    case (quad_r)
      2'd0:    begin c_map = xc[31:0];     s_map = yc[31:0];     end
      2'd1:    begin c_map = -yc[31:0];    s_map = xc[31:0];     end
      2'd2:    begin c_map = -xc[31:0];    s_map = -yc[31:0];    end
      default: begin c_map = yc[31:0];     s_map = -xc[31:0];    end
    endcase

    uop   = eulr_pkg::uop_at(step_r);
    opd_a = pick(uop.src_a, sc_r, t1_r, t3_r);
    opd_b = pick(uop.src_b, sc_r, t1_r, t3_r);

    prod_rnd = (prod_r + 64'sd536870912) >>> 30;
    rq       = prod_rnd[33:0];
    case (uop.mode)
      eulr_pkg::ACC_SET: acc_nxt = rq;
      eulr_pkg::ACC_ADD: acc_nxt = acc_r + rq;
      eulr_pkg::ACC_SUB: acc_nxt = acc_r - rq;
      default:           acc_nxt = -rq;
    endcase
    acc_clamp = clamp1(acc_nxt);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      eulr_pkg::MG_IDLE:   if (cfg_hit) state_nxt = eulr_pkg::MG_PH_LO;
      eulr_pkg::MG_PH_LO:  state_nxt = eulr_pkg::MG_PH_HI;
      eulr_pkg::MG_PH_HI:  state_nxt = eulr_pkg::MG_PH_SUM;
      eulr_pkg::MG_PH_SUM: state_nxt = eulr_pkg::MG_CINIT;
      eulr_pkg::MG_CINIT:  state_nxt = eulr_pkg::MG_CORDIC;
      eulr_pkg::MG_CORDIC:
        if (iter_r == 5'(eulr_pkg::CORDIC_ITERS - 1)) state_nxt = eulr_pkg::MG_MAP;
      eulr_pkg::MG_MAP:
        state_nxt = (ang_sel_r == 2'd2) ? eulr_pkg::MG_MUL : eulr_pkg::MG_PH_LO;
      eulr_pkg::MG_MUL:    state_nxt = eulr_pkg::MG_ACC;
      eulr_pkg::MG_ACC:
        state_nxt = (step_r == 4'(eulr_pkg::UOP_LAST)) ? eulr_pkg::MG_IDLE
                                                      : eulr_pkg::MG_MUL;
      default:             state_nxt = eulr_pkg::MG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= eulr_pkg::MG_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_z_r <= '0;
      ang_x_r <= '0;
      ang_y_r <= '0;
      deg_r   <= 1'b1;
      for (int i = 0; i < 9; i++)
        rot_r[i] <= (i % 4 == 0) ? eulr_pkg::ONE_Q30[31:0] : 32'sd0;
    end else begin
      if (state_r == eulr_pkg::MG_IDLE && cfg_valid) begin
        case (cfg_index)
          eulr_pkg::REG_ANGLE_Z: ang_z_r <= cfg_data[eulr_pkg::ANGLE_W-1:0];
          eulr_pkg::REG_ANGLE_X: ang_x_r <= cfg_data[eulr_pkg::ANGLE_W-1:0];
          eulr_pkg::REG_ANGLE_Y: ang_y_r <= cfg_data[eulr_pkg::ANGLE_W-1:0];
          eulr_pkg::REG_DEGREES: deg_r   <= cfg_data[0];
          default: ;
        endcase
      end
      if (state_r == eulr_pkg::MG_ACC && uop.last && uop.dst < eulr_pkg::DST_T1)
        rot_r[uop.dst] <= acc_clamp[31:0];
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      eulr_pkg::MG_IDLE: begin
        ang_sel_r <= 2'd0;
        step_r    <= 4'd0;
      end
      eulr_pkg::MG_PH_LO: plo_r <= ang_cur * $signed({1'b0, kmul[18:0]});
      eulr_pkg::MG_PH_HI: phi_r <= ang_cur * $signed({1'b0, kmul[37:19]});
      eulr_pkg::MG_PH_SUM: phase_r <= phase_sum[55:24];
      eulr_pkg::MG_CINIT: begin
        quad_r <= qsum[31:30];
        z_r    <= 34'($signed(dsub));
        x_r    <= eulr_pkg::CORDIC_GAIN;
        y_r    <= '0;
        iter_r <= 5'd0;
      end
      eulr_pkg::MG_CORDIC: begin
        if (!z_r[33]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - atan_ext;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + atan_ext;
        end
        iter_r <= iter_r + 5'd1;
      end
      eulr_pkg::MG_MAP: begin
        sc_r[{ang_sel_r, 1'b0}] <= c_map;
        sc_r[{ang_sel_r, 1'b1}] <= s_map;
        ang_sel_r <= ang_sel_r + 2'd1;
      end
      eulr_pkg::MG_MUL: prod_r <= opd_a * opd_b;
      eulr_pkg::MG_ACC: begin
        acc_r <= acc_nxt;
        if (uop.dst == eulr_pkg::DST_T1) t1_r <= rq[31:0];
        if (uop.dst == eulr_pkg::DST_T3) t3_r <= rq[31:0];
        step_r <= step_r + 4'd1;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/euler_zxy_rotation_transform.sv =====
`timescale 1ns / 1ps

// euler angle rotation block, rotation order z then x then y
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0..2 load
//   angle z, x, y (26-bit signed, 16 fractional bits), index 3 bit 0 selects degrees;
//   other indexes are taken and ignored
// every accepted write to index 0..3 rebuilds the matrix: per angle phase setup
//   (ph_lo, ph_hi, ph_sum, cinit), 31 cordic iterations on one shared shift-add unit
//   and a quadrant map, then 15 multiply steps (mul, acc); cfg_ready and in_ready
//   stay low until the rebuild is done
// input channel: in_valid/in_ready with one in_item_t per transaction (opcode and
//   nine q16.16 components); output channel: out_valid/out_ready with one out_item_t
// throughput: one transaction per cycle unless the output stalls or a rebuild runs;
//   pipeline of two rows of parallel multipliers each followed by a sum stage
// reset: synchronous, active low; angles zero, degrees mode, identity matrix
// when the receiver stalls the whole pipeline holds and in_ready drops, so nothing
//   is lost or repeated

module euler_zxy_rotation_transform (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  eulr_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output eulr_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [eulr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [eulr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic               mg_idle;
  logic signed [31:0] rot [9];

  // matrix generator: angle registers, cordic and matrix build
  eulr_matgen u_matgen (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .idle       (mg_idle),
    .rot_matrix (rot)
  );

  // global advance: a stage moves when the output register is free or drains
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en && mg_idle;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) r = 32'sh7fff_ffff;
    else if (x < -66'sd2147483648) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  // stage 1: a*b products, a = r or r transposed, b = tensor or vector in column 0
  logic               v1_r;
  logic [1:0]         op1_r;
  logic signed [63:0] m1_r [27];
  logic signed [31:0] tin [9];
  logic signed [31:0] a_m [9];
  logic signed [31:0] b_m [9];

  always_comb begin
    tin[0] = in_data.in_c0; tin[1] = in_data.in_c1; tin[2] = in_data.in_c2;
    tin[3] = in_data.in_c3; tin[4] = in_data.in_c4; tin[5] = in_data.in_c5;
    tin[6] = in_data.in_c6; tin[7] = in_data.in_c7; tin[8] = in_data.in_c8;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        a_m[i*3+j] = (in_data.opcode == eulr_pkg::OP_INV) ? rot[j*3+i] : rot[i*3+j];
        if (in_data.opcode == eulr_pkg::OP_TENSOR) b_m[i*3+j] = tin[i*3+j];
        else b_m[i*3+j] = (j == 0) ? tin[i] : 32'sd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= in_data.opcode;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          for (int k = 0; k < 3; k++)
            m1_r[(i*3+j)*3+k] <= a_m[i*3+k] * b_m[k*3+j];
    end
  end

  // stage 2: p = round(sum, 30 bits)
  logic               v2_r;
  logic [1:0]         op2_r;
  logic signed [33:0] p2_r [9];
  logic signed [63:0] s2 [9];

  always_comb begin
    for (int n = 0; n < 9; n++)
      s2[n] = m1_r[n*3] + m1_r[n*3+1] + m1_r[n*3+2] + 64'sd536870912;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r <= op1_r;
      for (int n = 0; n < 9; n++) p2_r[n] <= s2[n][63:30];
    end
  end

  // stage 3: p * r transposed, each product floored by 2 bits
  logic               v3_r;
  logic [1:0]         op3_r;
  logic signed [63:0] m3_r [27];
  logic signed [33:0] p3_r [3];
  logic signed [65:0] pr3 [27];

  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        for (int k = 0; k < 3; k++)
          pr3[(i*3+j)*3+k] = p2_r[i*3+k] * rot[j*3+k];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op3_r <= op2_r;
      for (int n = 0; n < 27; n++) m3_r[n] <= pr3[n][65:2];
      for (int i = 0; i < 3; i++) p3_r[i] <= p2_r[i*3];
    end
  end

  // stage 4: final sum, round by 28 bits, saturate; vectors take column 0 of p
  logic signed [31:0] res [9];
  logic signed [65:0] s4;

  always_comb begin
    s4 = '0;
    for (int n = 0; n < 9; n++) begin
      s4 = 66'(m3_r[n*3]) + 66'(m3_r[n*3+1]) + 66'(m3_r[n*3+2]) + 66'sd134217728;
      case (op3_r)
        eulr_pkg::OP_TENSOR: res[n] = sat32(s4 >>> 28);
        eulr_pkg::OP_FWD, eulr_pkg::OP_INV:
          res[n] = (n < 3) ? sat32(66'(p3_r[n % 3])) : 32'sd0;
        default: res[n] = 32'sd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.out_c0 <= res[0];
      out_data.out_c1 <= res[1];
      out_data.out_c2 <= res[2];
      out_data.out_c3 <= res[3];
      out_data.out_c4 <= res[4];
      out_data.out_c5 <= res[5];
      out_data.out_c6 <= res[6];
      out_data.out_c7 <= res[7];
      out_data.out_c8 <= res[8];
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1_r      <= in_valid && in_ready;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      out_valid <= v3_r;
    end
  end

endmodule

// ===== dv/euler_zxy_rotation_transform_tb.sv =====
`timescale 1ns / 1ps

module euler_zxy_rotation_transform_tb;

  localparam longint ONE_Q30_L = 64'sd1 << 30;
  localparam int     SETTLE_CYCLES = 12;   // margin on top of the pipeline depth
  localparam int     HOLD_CYCLES = 400;    // long output stall to back up the pipe
  localparam int     ITEMS_PER_PHASE = 250;
  localparam logic [eulr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // cordic arc table in units of 2^-32 turn
  localparam longint ARC_TURN [31] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  eulr_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  eulr_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [eulr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [eulr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  euler_zxy_rotation_transform i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor copy of the register file and matrix
  logic [eulr_pkg::ANGLE_W-1:0] ang_z_q, ang_x_q, ang_y_q;
  logic               deg_mode_q;
  longint             rot_q [9];

  eulr_pkg::in_item_t  pending_items [$];
  eulr_pkg::out_item_t expected_rot [$];
  int        errors = 0;
  int        idle_pct = 18;   // percent of cycles each side idles
  bit        stall_go = 1'b0; // request for the long output hold
  bit        stall_taken = 1'b0;
  int        hold_cnt = 0;

  function automatic longint round_up(longint x, int s);
    if (s == 0) return x;
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_mag(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic longint sat_data(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return round_up(a * b, eulr_pkg::MAT_FRAC);
  endfunction

  // angle register to phase in 2^-32 turn
  function automatic logic [31:0] angle_phase(logic [eulr_pkg::ANGLE_W-1:0] ang);
    longint unsigned a, k, p;
    a = longint'(signed'(ang));
    k = deg_mode_q ? 64'd3054198966 : 64'd174992710547;
    p = a * k + (64'd1 << 23);
    return p[55:24];
  endfunction

  task automatic cordic_sincos(input logic [31:0] phase, output longint c, output longint s);
    logic [31:0] quad, d;
    longint x, y, z, dx, dy;
    quad = ((phase + 32'h2000_0000) >> 30) & 32'd3;
    d = phase - (quad << 30);
    z = longint'(signed'(d));
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < 31; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARC_TURN[i];
      end else begin
        x += dx; y -= dy; z += ARC_TURN[i];
      end
    end
    x = clamp_mag(x, ONE_Q30_L);
    y = clamp_mag(y, ONE_Q30_L);
    case (quad)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  task automatic rebuild_rotation();
    longint cz, sz, cx, sx, cy, sy;
    longint m [9];
    cordic_sincos(angle_phase(ang_z_q), cz, sz);
    cordic_sincos(angle_phase(ang_x_q), cx, sx);
    cordic_sincos(angle_phase(ang_y_q), cy, sy);
    m[0] = mul_q30(cy, cz) - mul_q30(mul_q30(sx, sy), sz);
    m[1] = -mul_q30(cx, sz);
    m[2] = mul_q30(mul_q30(sx, cy), sz) + mul_q30(sy, cz);
    m[3] = mul_q30(cy, sz) + mul_q30(mul_q30(sx, sy), cz);
    m[4] = mul_q30(cx, cz);
    m[5] = mul_q30(sy, sz) - mul_q30(mul_q30(sx, cy), cz);
    m[6] = -mul_q30(cx, sy);
    m[7] = sx;
    m[8] = mul_q30(cx, cy);
    for (int i = 0; i < 9; i++) rot_q[i] = clamp_mag(m[i], ONE_Q30_L);
  endtask

  task automatic reset_model();
    ang_z_q = '0; ang_x_q = '0; ang_y_q = '0; deg_mode_q = 1'b1;
    for (int i = 0; i < 9; i++) rot_q[i] = (i % 4 == 0) ? ONE_Q30_L : 0;
  endtask

  function automatic eulr_pkg::out_item_t rotate_item(eulr_pkg::in_item_t it);
    longint t [9];
    longint p [9];
    longint res [9];
    longint acc;
    eulr_pkg::out_item_t o;
    t = '{it.in_c0, it.in_c1, it.in_c2, it.in_c3, it.in_c4,
          it.in_c5, it.in_c6, it.in_c7, it.in_c8};
    for (int i = 0; i < 9; i++) res[i] = 0;
    if (it.opcode == eulr_pkg::OP_FWD || it.opcode == eulr_pkg::OP_INV) begin
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int k = 0; k < 3; k++)
          acc += ((it.opcode == eulr_pkg::OP_FWD) ? rot_q[i*3+k] : rot_q[k*3+i]) * t[k];
        res[i] = sat_data(round_up(acc, eulr_pkg::MAT_FRAC));
      end
    end else if (it.opcode == eulr_pkg::OP_TENSOR) begin
      // p = r*t kept wide, then p*r^t with each product floored by 2 bits
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += rot_q[i*3+k] * t[k*3+j];
          p[i*3+j] = round_up(acc, eulr_pkg::MAT_FRAC);
        end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += (p[i*3+k] * rot_q[j*3+k]) >>> 2;
          res[i*3+j] = sat_data(round_up(acc, eulr_pkg::MAT_FRAC - 2));
        end
    end
    // unused opcode leaves everything zero
    o.out_c0 = res[0][31:0]; o.out_c1 = res[1][31:0]; o.out_c2 = res[2][31:0];
    o.out_c3 = res[3][31:0]; o.out_c4 = res[4][31:0]; o.out_c5 = res[5][31:0];
    o.out_c6 = res[6][31:0]; o.out_c7 = res[7][31:0]; o.out_c8 = res[8][31:0];
    return o;
  endfunction

  // driver: one transaction held on in_data until accepted
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_rot.push_back(rotate_item(pending_items[0]));
        void'(pending_items.pop_front());
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_items[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    eulr_pkg::out_item_t exp_o;
    logic [31:0] got [9];
    logic [31:0] want [9];
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_rot.size() == 0) begin
          $error("result with no transaction outstanding");
          errors++;
        end else begin
          exp_o = expected_rot.pop_front();
          got  = '{out_data.out_c0, out_data.out_c1, out_data.out_c2, out_data.out_c3,
                   out_data.out_c4, out_data.out_c5, out_data.out_c6, out_data.out_c7,
                   out_data.out_c8};
          want = '{exp_o.out_c0, exp_o.out_c1, exp_o.out_c2, exp_o.out_c3, exp_o.out_c4,
                   exp_o.out_c5, exp_o.out_c6, exp_o.out_c7, exp_o.out_c8};
          for (int i = 0; i < 9; i++)
            if (got[i] !== want[i]) begin
              $error("out_c%0d expected %0d actual %0d", i, $signed(want[i]),
                     $signed(got[i]));
              errors++;
            end
        end
      end
    end
  end

  // receiver ready, with the long hold counted here
  always @(posedge clk) begin
    if (rst_n) begin
      if (stall_go && !stall_taken) begin
        stall_taken = 1'b1;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'd0;
      3: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;  // around +-8
      4: return ($urandom_range(0, 64) - 32) << 16;                 // whole units
      default: return $urandom;
    endcase
  endfunction

  function automatic eulr_pkg::in_item_t rand_item();
    eulr_pkg::in_item_t it;
    it.opcode = ($urandom_range(19) == 0) ? OP_UNUSED : 2'($urandom_range(2));
    it.in_c0 = rand_comp(); it.in_c1 = rand_comp(); it.in_c2 = rand_comp();
    it.in_c3 = rand_comp(); it.in_c4 = rand_comp(); it.in_c5 = rand_comp();
    it.in_c6 = rand_comp(); it.in_c7 = rand_comp(); it.in_c8 = rand_comp();
    return it;
  endfunction

  function automatic eulr_pkg::in_item_t flat_item(logic [1:0] op, logic [31:0] v);
    return '{op, v, v, v, v, v, v, v, v, v};
  endfunction

  task automatic write_reg(input logic [eulr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      eulr_pkg::REG_ANGLE_Z: ang_z_q = val[eulr_pkg::ANGLE_W-1:0];
      eulr_pkg::REG_ANGLE_X: ang_x_q = val[eulr_pkg::ANGLE_W-1:0];
      eulr_pkg::REG_ANGLE_Y: ang_y_q = val[eulr_pkg::ANGLE_W-1:0];
      eulr_pkg::REG_DEGREES: deg_mode_q = val[0];
      default: ;
    endcase
    if (idx <= eulr_pkg::REG_DEGREES) rebuild_rotation();
  endtask

  task automatic set_angles(input logic [31:0] z, input logic [31:0] x,
                            input logic [31:0] y, input logic deg);
    write_reg(eulr_pkg::REG_DEGREES, {31'd0, deg});
    write_reg(eulr_pkg::REG_ANGLE_Z, z);
    write_reg(eulr_pkg::REG_ANGLE_X, x);
    write_reg(eulr_pkg::REG_ANGLE_Y, y);
  endtask

  // block must be idle before any register write
  task automatic drain();
    while (pending_items.size() > 0 || expected_rot.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_angle();
    return $urandom_range(0, 47185920) - 32'd23592960;
  endfunction

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) pending_items.push_back(rand_item());
  endtask

  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // identity matrix: extremes and every opcode, including the unused one
    pending_items.push_back('{eulr_pkg::OP_FWD, 32'h0001_0000, 32'h0002_0000,
                              32'hfffd_0000, 32'd5, 32'd6, 32'd7, 32'd8, 32'd9, 32'd10});
    pending_items.push_back('{eulr_pkg::OP_INV, 32'h0001_0000, 32'h0002_0000,
                              32'hfffd_0000, 32'd5, 32'd6, 32'd7, 32'd8, 32'd9, 32'd10});
    pending_items.push_back('{eulr_pkg::OP_TENSOR, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5,
                              32'd6, 32'd7, 32'd8, 32'd9});
    for (int op = 0; op < 4; op++) begin
      pending_items.push_back(flat_item(2'(op), 32'h7fff_ffff));
      pending_items.push_back(flat_item(2'(op), 32'h8000_0000));
      pending_items.push_back(flat_item(2'(op), 32'hffff_ffff));
    end
    pending_items.push_back(flat_item(OP_UNUSED, 32'h1234_5678));
    queue_random(ITEMS_PER_PHASE);
    drain();

    // 90 degrees everywhere lands on quadrant edges, then saturating extremes
    set_angles(32'h005a_0000, 32'h005a_0000, 32'h005a_0000, 1'b1);
    for (int op = 0; op < 3; op++) begin
      pending_items.push_back(flat_item(2'(op), 32'h7fff_ffff));
      pending_items.push_back(flat_item(2'(op), 32'h8000_0000));
    end
    queue_random(ITEMS_PER_PHASE);
    drain();

    // 45 degree quadrant boundary and negative angles
    set_angles(32'h002d_0000, 32'hffd3_0000, 32'hffc4_0000, 1'b1);
    queue_random(ITEMS_PER_PHASE);
    drain();

    // range extremes in degrees, no idling at all for this stretch
    set_angles(32'd23592960, -32'sd23592960, 32'd23592960, 1'b1);
    idle_pct = 0;
    queue_random(ITEMS_PER_PHASE);
    drain();
    idle_pct = 18;

    // radians, extremes and near pi
    set_angles(32'd65536, -32'sd23592960, 32'd205887, 1'b0);
    queue_random(ITEMS_PER_PHASE);
    drain();

    // out of range index is ignored; full 32-bit data wraps the angle
    write_reg(REG_UNUSED, $urandom);
    set_angles($urandom, $urandom, $urandom, 1'b1);
    // long output hold while the sender keeps offering
    stall_go = 1'b1;
    queue_random(ITEMS_PER_PHASE);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      set_angles(rand_angle(), rand_angle(), rand_angle(), 1'($urandom_range(1)));
      queue_random(ITEMS_PER_PHASE);
      drain();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
